### sv/xcfr_pkg.sv
// ----------------------------------------------------------------------------
// xcfr_pkg
// shared types and constants for the xor checked frame receiver
// ----------------------------------------------------------------------------
package xcfr_pkg;

	localparam logic [7:0]  SYNC_FIRST  = 8'hBE;
	localparam logic [7:0]  SYNC_SECOND = 8'hEF;

	localparam logic [7:0]  SHORT_LEN_RST  = 8'd4;
	localparam logic [7:0]  LONG_LEN_RST   = 8'd177;
	localparam logic [15:0] IDLE_LIMIT_RST = 16'd2000;

	typedef enum logic [1:0] {
		CFG_SHORT_LEN  = 2'd0,
		CFG_LONG_LEN   = 2'd1,
		CFG_IDLE_LIMIT = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STAT_NONE    = 2'd0,
		STAT_GOOD    = 2'd1,
		STAT_BAD_SUM = 2'd2,
		STAT_REJECT  = 2'd3
	} frame_stat_t;

	typedef enum logic {
		REQ_BYTE = 1'b0,
		REQ_TICK = 1'b1
	} req_t;

	typedef struct packed {
		logic [7:0]  short_len;
		logic [7:0]  long_len;
		logic [15:0] idle_limit;
	} cfg_t;

	typedef struct packed {
		logic        data_valid;
		logic [7:0]  data_index;
		logic [7:0]  data_value;
		frame_stat_t frame_status;
		logic        frame_kind;
		logic        connected;
		logic        link_lost;
	} result_t;

endpackage

### sv/xcfr_regs.sv
// ----------------------------------------------------------------------------
// xcfr_regs
// configuration registers: frame lengths and idle limit
// ----------------------------------------------------------------------------
module xcfr_regs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	output xcfr_pkg::cfg_t cfg
);
	import xcfr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_len  <= SHORT_LEN_RST;
			cfg_q.long_len   <= LONG_LEN_RST;
			cfg_q.idle_limit <= IDLE_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SHORT_LEN:  cfg_q.short_len  <= cfg_data[7:0];
				CFG_LONG_LEN:   cfg_q.long_len   <= cfg_data[7:0];
				CFG_IDLE_LIMIT: cfg_q.idle_limit <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

### sv/xcfr_parse.sv
// ----------------------------------------------------------------------------
// xcfr_parse
// input register, frame state machine, checksum and idle watchdog
// ----------------------------------------------------------------------------
module xcfr_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [7:0]        rx_byte,
	input  xcfr_pkg::cfg_t    cfg,
	input  logic              res_ready,
	output logic              res_valid,
	output xcfr_pkg::result_t res
);
	import xcfr_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_LEN   = 3'd2,
		PH_ID    = 3'd3,
		PH_DATA  = 3'd4,
		PH_CHECK = 3'd5
	} phase_t;

	logic        valid_s1;
	req_t        req_s1;
	logic [7:0]  byte_s1;
	logic        adv;

	phase_t      phase_q, phase_n;
	logic [7:0]  len_q, len_n;
	logic        ident_q, ident_n;
	logic [7:0]  pos_q, pos_n;
	logic [7:0]  xor_q, xor_n;
	logic [15:0] idle_q, idle_n;
	logic        link_q, link_n;
	logic [16:0] idle_inc;
	logic        hdr_ok;

	assign adv       = valid_s1 && res_ready;
	assign in_ready  = !valid_s1 || res_ready;
	assign res_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1  <= req_t'(req_type);
			byte_s1 <= rx_byte;
		end
	end

	assign idle_inc = {1'b0, idle_q} + 17'd1;
	assign hdr_ok   = (len_q != 8'd0) &&
		((byte_s1 == 8'd0 && len_q == cfg.short_len) ||
		 (byte_s1 == 8'd1 && len_q == cfg.long_len));

	always_comb begin
		phase_n = phase_q;
		len_n   = len_q;
		ident_n = ident_q;
		pos_n   = pos_q;
		xor_n   = xor_q;
		idle_n  = idle_q;
		link_n  = link_q;
		res     = '0;
		if (req_s1 == REQ_TICK) begin
			if (idle_inc > {1'b0, cfg.idle_limit}) begin
				link_n        = 1'b0;
				idle_n        = '0;
				res.link_lost = 1'b1;
			end else begin
				idle_n = idle_inc[15:0];
			end
		end else begin
			case (phase_q)
				PH_SYNC2: begin
					phase_n = (byte_s1 == SYNC_SECOND) ? PH_LEN : PH_HUNT;
				end
				PH_LEN: begin
					len_n   = byte_s1;
					xor_n   = byte_s1;
					phase_n = PH_ID;
				end
				PH_ID: begin
					if (hdr_ok) begin
						ident_n        = byte_s1[0];
						xor_n          = xor_q ^ byte_s1;
						pos_n          = 8'd1;
						res.data_valid = 1'b1;
						res.data_value = byte_s1;
						phase_n        = (len_q == 8'd1) ? PH_CHECK : PH_DATA;
					end else begin
						res.frame_status = STAT_REJECT;
						phase_n          = PH_HUNT;
					end
				end
				PH_DATA: begin
					xor_n          = xor_q ^ byte_s1;
					res.data_valid = 1'b1;
					res.data_index = pos_q;
					res.data_value = byte_s1;
					pos_n          = pos_q + 8'd1;
					if (pos_n == len_q) begin
						phase_n = PH_CHECK;
					end
				end
				PH_CHECK: begin
					if (byte_s1 == xor_q) begin
						res.frame_status = STAT_GOOD;
						link_n           = 1'b1;
						idle_n           = '0;
					end else begin
						res.frame_status = STAT_BAD_SUM;
					end
					phase_n = PH_HUNT;
				end
				default: begin
					phase_n = (byte_s1 == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
				end
			endcase
		end
		res.frame_kind = ident_n;
		res.connected  = link_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q   <= '0;
			ident_q <= 1'b0;
			pos_q   <= '0;
			xor_q   <= '0;
			idle_q  <= '0;
			link_q  <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_n;
			len_q   <= len_n;
			ident_q <= ident_n;
			pos_q   <= pos_n;
			xor_q   <= xor_n;
			idle_q  <= idle_n;
			link_q  <= link_n;
		end
	end

	a_good_sets_link: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.frame_status == STAT_GOOD |=> link_q && idle_q == 16'd0)
		else $error("good frame did not raise the link");

	a_lost_clears_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.link_lost |=> !link_q && idle_q == 16'd0)
		else $error("link loss did not clear link and idle count");

	a_data_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res.data_valid |-> res.frame_status == STAT_NONE && !res.link_lost)
		else $error("data word carries a frame status");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(phase_q) && $stable(idle_q) && $stable(link_q))
		else $error("state changed without a word");

endmodule

### sv/xcfr_out.sv
// ----------------------------------------------------------------------------
// xcfr_out
// result register between the parser and the output channel
// ----------------------------------------------------------------------------
module xcfr_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	output logic              res_ready,
	input  xcfr_pkg::result_t res,
	output logic              out_valid,
	input  logic              out_ready,
	output xcfr_pkg::result_t out_res
);
	import xcfr_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	assign res_ready = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_res   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_ready) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_s2 <= res;
		end
	end

endmodule

### sv/xor_checked_frame_receiver.sv
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver
// sync word framed receiver with xor checksum and idle watchdog
//
//   channel  handshake             payload
//   in       in_valid / in_ready   req_type, rx_byte
//   out      out_valid / out_ready data_valid, data_index, data_value,
//                                  frame_status, frame_kind, connected, link_lost
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one word per cycle while out_ready is high; a result is registered twice after
// its word is taken (input register, then result register)
// all control state clears on arst_n; cfg_ready is always high
// a stalled output holds its word while one more input word can be taken
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        data_valid,
	output logic [7:0]  data_index,
	output logic [7:0]  data_value,
	output logic [1:0]  frame_status,
	output logic        frame_kind,
	output logic        connected,
	output logic        link_lost,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import xcfr_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t out_res;
	logic    res_valid;
	logic    res_ready;

	xcfr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	xcfr_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.rx_byte   (rx_byte),
		.cfg       (cfg),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	xcfr_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign data_valid   = out_res.data_valid;
	assign data_index   = out_res.data_index;
	assign data_value   = out_res.data_value;
	assign frame_status = out_res.frame_status;
	assign frame_kind   = out_res.frame_kind;
	assign connected    = out_res.connected;
	assign link_lost    = out_res.link_lost;

endmodule

### tb/xor_checked_frame_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_test
// self-checking bench for the sync word framed receiver
//
// every accepted input word is run through a cycle-free model of the frame
// parser and idle watchdog; the expected result word is queued and each
// result word is compared field by field with the oldest entry. directed
// frames cover sync errors, header rejects, checksum errors, the shortest
// and longest frames and the watchdog; random traffic then mixes good frames
// with noise, broken headers and ticks under changing register settings and
// random backpressure on both channels, plus one long output stall.
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver_test;

	import xcfr_pkg::*;

	localparam int         CYCLE_LIMIT  = 300000;
	localparam int         PRINT_LIMIT  = 100;
	localparam logic [1:0] CFG_UNMAPPED = 2'd3;

	typedef enum logic [2:0] {
		WAIT_BE,
		WAIT_EF,
		GET_LEN,
		GET_ID,
		GET_BODY,
		GET_SUM
	} rx_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        req_type = 1'b0;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        data_valid;
	logic [7:0]  data_index;
	logic [7:0]  data_value;
	logic [1:0]  frame_status;
	logic        frame_kind;
	logic        connected;
	logic        link_lost;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [15:0] cfg_data = 16'd0;

	xor_checked_frame_receiver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_valid   (data_valid),
		.data_index   (data_index),
		.data_value   (data_value),
		.frame_status (frame_status),
		.frame_kind   (frame_kind),
		.connected    (connected),
		.link_lost    (link_lost),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// model registers and state
	logic [7:0]  m_short_len  = SHORT_LEN_RST;
	logic [7:0]  m_long_len   = LONG_LEN_RST;
	logic [15:0] m_idle_limit = IDLE_LIMIT_RST;
	rx_phase_t   m_phase      = WAIT_BE;
	logic [7:0]  m_frame_len  = 8'd0;
	logic        m_kind       = 1'b0;
	logic [7:0]  m_pos        = 8'd0;
	logic [7:0]  m_sum        = 8'd0;
	logic [15:0] m_idle_cnt   = 16'd0;
	logic        m_link       = 1'b0;

	result_t pending_results[$];
	result_t want;
	int      err_count = 0;
	int      cycle_count = 0;
	int      words_sent = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	int      hold_req = 0;
	int      hold_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic result_t frame_rx_step(logic is_tick, logic [7:0] b);
		result_t     r;
		logic [16:0] next_cnt;
		r = '0;
		r.frame_status = STAT_NONE;
		if (is_tick == REQ_TICK) begin
			next_cnt = {1'b0, m_idle_cnt} + 17'd1;
			if (next_cnt > {1'b0, m_idle_limit}) begin
				m_link = 1'b0;
				m_idle_cnt = 16'd0;
				r.link_lost = 1'b1;
			end else begin
				m_idle_cnt = next_cnt[15:0];
			end
		end else begin
			case (m_phase)
				WAIT_EF: begin
					if (b == SYNC_SECOND)
						m_phase = GET_LEN;
					else
						m_phase = WAIT_BE;
				end
				GET_LEN: begin
					m_frame_len = b;
					m_sum = b;
					m_phase = GET_ID;
				end
				GET_ID: begin
					if (m_frame_len != 8'd0 &&
					    ((b == 8'd0 && m_frame_len == m_short_len) ||
					     (b == 8'd1 && m_frame_len == m_long_len))) begin
						m_kind = b[0];
						m_sum = m_sum ^ b;
						m_pos = 8'd1;
						r.data_valid = 1'b1;
						r.data_index = 8'd0;
						r.data_value = b;
						if (m_frame_len == 8'd1)
							m_phase = GET_SUM;
						else
							m_phase = GET_BODY;
					end else begin
						r.frame_status = STAT_REJECT;
						m_phase = WAIT_BE;
					end
				end
				GET_BODY: begin
					m_sum = m_sum ^ b;
					r.data_valid = 1'b1;
					r.data_index = m_pos;
					r.data_value = b;
					m_pos = m_pos + 8'd1;
					if (m_pos == m_frame_len)
						m_phase = GET_SUM;
				end
				GET_SUM: begin
					if (b == m_sum) begin
						r.frame_status = STAT_GOOD;
						m_link = 1'b1;
						m_idle_cnt = 16'd0;
					end else begin
						r.frame_status = STAT_BAD_SUM;
					end
					m_phase = WAIT_BE;
				end
				default: begin
					if (b == SYNC_FIRST)
						m_phase = WAIT_EF;
					else
						m_phase = WAIT_BE;
				end
			endcase
		end
		r.frame_kind = m_kind;
		r.connected = m_link;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
	                               input logic [15:0] exp_val);
		if (err_count < PRINT_LIMIT)
			$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp_val);
		err_count++;
	endtask

	// result checking, prediction and register mirror
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result word with nothing pending", 16'd0, 16'd0);
			end else begin
				want = pending_results.pop_front();
				if (data_valid !== want.data_valid)
					report_mismatch("data_valid", 16'(data_valid),
					                16'(want.data_valid));
				if (data_index !== want.data_index)
					report_mismatch("data_index", 16'(data_index),
					                16'(want.data_index));
				if (data_value !== want.data_value)
					report_mismatch("data_value", 16'(data_value),
					                16'(want.data_value));
				if (frame_status !== want.frame_status)
					report_mismatch("frame_status", 16'(frame_status),
					                16'(want.frame_status));
				if (frame_kind !== want.frame_kind)
					report_mismatch("frame_kind", 16'(frame_kind),
					                16'(want.frame_kind));
				if (connected !== want.connected)
					report_mismatch("connected", 16'(connected),
					                16'(want.connected));
				if (link_lost !== want.link_lost)
					report_mismatch("link_lost", 16'(link_lost),
					                16'(want.link_lost));
			end
		end
		if (in_valid && in_ready)
			pending_results.push_back(frame_rx_step(req_type, rx_byte));
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SHORT_LEN:  m_short_len = cfg_data[7:0];
				CFG_LONG_LEN:   m_long_len = cfg_data[7:0];
				CFG_IDLE_LIMIT: m_idle_limit = cfg_data;
				default: ;
			endcase
		end
	end

	// receiver side: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_word(input req_t kind, input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic maybe_tick(input int pct);
		if ($urandom_range(99) < pct)
			send_word(REQ_TICK, 8'($urandom));
	endtask

	// sync, length, id, body, checksum; ticks may fall between any two words
	task automatic send_frame(input logic [7:0] id, input int len, input bit bad_sum,
	                          input int tick_pct);
		logic [7:0] sum;
		logic [7:0] b;
		send_word(REQ_BYTE, SYNC_FIRST);
		maybe_tick(tick_pct);
		send_word(REQ_BYTE, SYNC_SECOND);
		maybe_tick(tick_pct);
		send_word(REQ_BYTE, 8'(len));
		maybe_tick(tick_pct);
		sum = 8'(len) ^ id;
		send_word(REQ_BYTE, id);
		for (int i = 1; i < len; i++) begin
			maybe_tick(tick_pct);
			b = 8'($urandom);
			sum = sum ^ b;
			send_word(REQ_BYTE, b);
		end
		maybe_tick(tick_pct);
		if (bad_sum)
			sum = sum ^ 8'($urandom_range(1, 255));
		send_word(REQ_BYTE, sum);
	endtask

	task automatic test_directed_frames();
		send_frame(8'd0, int'(SHORT_LEN_RST), 1'b0, 0);
		send_word(REQ_BYTE, SYNC_FIRST);
		send_word(REQ_BYTE, SYNC_FIRST);
		send_word(REQ_BYTE, SYNC_SECOND);
		send_word(REQ_BYTE, SYNC_FIRST);
		send_word(REQ_BYTE, 8'h00);
		// bad id, wrong length, zero length
		send_word(REQ_BYTE, SYNC_FIRST);
		send_word(REQ_BYTE, SYNC_SECOND);
		send_word(REQ_BYTE, SHORT_LEN_RST);
		send_word(REQ_BYTE, 8'hFF);
		send_word(REQ_BYTE, SYNC_FIRST);
		send_word(REQ_BYTE, SYNC_SECOND);
		send_word(REQ_BYTE, 8'd5);
		send_word(REQ_BYTE, 8'd0);
		send_word(REQ_BYTE, SYNC_FIRST);
		send_word(REQ_BYTE, SYNC_SECOND);
		send_word(REQ_BYTE, 8'd0);
		send_word(REQ_BYTE, 8'd0);
		send_word(REQ_TICK, 8'hFF);
		send_word(REQ_TICK, 8'h00);
	endtask

	task automatic test_config_extremes();
		write_reg(CFG_SHORT_LEN, 16'd1);
		write_reg(CFG_IDLE_LIMIT, 16'd1);
		send_frame(8'd0, 1, 1'b0, 0);
		send_frame(8'd0, 1, 1'b1, 0);
		send_frame(8'd0, 1, 1'b0, 0);
		send_word(REQ_TICK, 8'h55);
		send_word(REQ_TICK, 8'hAA);
		send_word(REQ_TICK, 8'h00);
		write_reg(CFG_LONG_LEN, 16'd255);
		write_reg(CFG_IDLE_LIMIT, 16'd65535);
		send_frame(8'd1, 255, 1'b0, 3);
		send_frame(8'd1, 1, 1'b0, 0);
		write_reg(CFG_SHORT_LEN, 16'd255);
		write_reg(CFG_LONG_LEN, 16'd1);
		send_frame(8'd0, 2, 1'b1, 0);
		send_frame(8'd1, 1, 1'b0, 2);
		send_frame(8'd1, 2, 1'b0, 0);
		// unmapped index must leave every register alone
		write_reg(CFG_UNMAPPED, 16'hFFFF);
		send_frame(8'd1, 1, 1'b0, 0);
		send_frame(8'd0, 4, 1'b0, 0);
	endtask

	task automatic randomize_regs();
		write_reg(CFG_SHORT_LEN, 16'($urandom_range(1, 6)));
		write_reg(CFG_LONG_LEN, 16'($urandom_range(1, 12)));
		if ($urandom_range(3) == 0)
			write_reg(CFG_IDLE_LIMIT, 16'($urandom_range(100, 65535)));
		else
			write_reg(CFG_IDLE_LIMIT, 16'($urandom_range(1, 40)));
	endtask

	task automatic test_random_traffic(input int budget, input int s_idle, input int r_idle);
		int         stop_at;
		int         next_cfg;
		int         pick;
		int         n;
		logic [7:0] id;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		stop_at = words_sent + budget;
		next_cfg = words_sent;
		while (words_sent < stop_at) begin
			if (words_sent >= next_cfg) begin
				randomize_regs();
				next_cfg = words_sent + $urandom_range(60, 120);
			end
			pick = $urandom_range(99);
			id = 8'($urandom_range(1));
			if (pick < 62) begin
				send_frame(id, int'((id == 8'd0) ? m_short_len : m_long_len),
				           ($urandom_range(99) < 15), 8);
			end else if (pick < 72) begin
				n = $urandom_range(1, 45);
				repeat (n) send_word(REQ_TICK, 8'($urandom));
			end else if (pick < 80) begin
				send_word(REQ_BYTE, SYNC_FIRST);
				if ($urandom_range(1))
					send_word(REQ_BYTE, SYNC_FIRST);
				else
					send_word(REQ_BYTE, 8'($urandom));
			end else if (pick < 87) begin
				send_word(REQ_BYTE, SYNC_FIRST);
				send_word(REQ_BYTE, SYNC_SECOND);
				send_word(REQ_BYTE, 8'($urandom_range(15)));
				send_word(REQ_BYTE, 8'($urandom_range(3)));
			end else if (pick < 94) begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					if ($urandom_range(3) == 0)
						send_word(REQ_BYTE, SYNC_FIRST);
					else
						send_word(REQ_BYTE, 8'($urandom));
				end
			end else begin
				send_frame(id, int'((id == 8'd0) ? m_long_len : m_short_len) + 1,
				           1'b0, 5);
			end
		end
		wait_drained();
	endtask

	task automatic test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_SHORT_LEN, 16'd3);
		write_reg(CFG_LONG_LEN, 16'd9);
		write_reg(CFG_IDLE_LIMIT, 16'd20);
		hold_req = 400;
		repeat (6) send_frame(8'($urandom_range(1)), 0, 1'b0, 0);
		repeat (4) begin
			id_frame_pair();
		end
		wait_drained();
	endtask

	task automatic id_frame_pair();
		send_frame(8'd0, 3, 1'b0, 10);
		send_frame(8'd1, 9, 1'b0, 10);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 6;
		recv_idle_pct = 73;
		test_directed_frames();
		test_config_extremes();
		wait_drained();
		test_random_traffic(130, 6, 73);
		test_random_traffic(130, 73, 6);
		test_random_traffic(130, 0, 0);
		test_output_stall();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
